/* design/valley_period_estimator_unit_macros.svh */
// Assertion macros for the valley period estimator
`ifndef VALLEY_PERIOD_ESTIMATOR_UNIT_MACROS_SVH
`define VALLEY_PERIOD_ESTIMATOR_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define VPE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset
`define VPE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/vpe_pkg.sv */
// Shared types and constants for the valley period estimator
package vpe_pkg;

	localparam int LEVEL_BITS   = 12;
	localparam int BOUND_BITS   = 16;
	localparam int SCALE_BITS   = 8;
	localparam int EST_BITS     = 24;
	localparam int CFG_IDX_BITS = 3;
	localparam int CFG_DAT_BITS = 16;

	localparam logic [EST_BITS-1:0] EST_MAX = '1;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_BITS-1:0] REG_VALLEY_LEVEL     = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_MIN_SPACING      = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_UPPER_BOUND      = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_LOWER_BOUND      = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_PERIOD_SCALE     = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_INITIAL_ESTIMATE = 3'd5;

	// Accepted-valley count codes
	localparam logic [1:0] ACC_NONE    = 2'd0;
	localparam logic [1:0] ACC_MEASURE = 2'd2;
	localparam logic [1:0] ACC_FULL    = 2'd3;

	// History fill count at which valleys are tested
	localparam logic [2:0] FILL_FULL = 3'd4;

	typedef struct packed {
		logic [LEVEL_BITS-1:0] valley_level;
		logic [BOUND_BITS-1:0] min_spacing;
		logic [BOUND_BITS-1:0] upper_bound;
		logic [BOUND_BITS-1:0] lower_bound;
		logic [SCALE_BITS-1:0] period_scale;
		logic [BOUND_BITS-1:0] initial_estimate;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		valley_level:     12'd3000,
		min_spacing:      16'd40,
		upper_bound:      16'd500,
		lower_bound:      16'd100,
		period_scale:     8'd1,
		initial_estimate: 16'd60
	};

endpackage

/* design/vpe_history.sv */
// Four-deep sample history and valley detector
module vpe_history
	import vpe_pkg::*;
#(
	parameter int SAMPLE_BITS = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  logic [LEVEL_BITS-1:0]  level,
	output logic                   valley
);

	localparam int CMP_BITS = (SAMPLE_BITS > LEVEL_BITS) ? SAMPLE_BITS : LEVEL_BITS;

	logic [SAMPLE_BITS-1:0] hist_q [4];
	logic [2:0]             fill_q;

	// Valley sits two back: below four back, below the new sample and below the level
	always_comb begin
		valley = (fill_q >= FILL_FULL) && (hist_q[1] < hist_q[3]) && (sample > hist_q[1])
			&& (CMP_BITS'(hist_q[1]) < CMP_BITS'(level));
	end

	// Shift the history and count warm-up samples
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q[0] <= '0;
			hist_q[1] <= '0;
			hist_q[2] <= '0;
			hist_q[3] <= '0;
			fill_q    <= '0;
		end else if (step) begin
			hist_q[3] <= hist_q[2];
			hist_q[2] <= hist_q[1];
			hist_q[1] <= hist_q[0];
			hist_q[0] <= sample;
			if (fill_q < FILL_FULL) begin
				fill_q <= fill_q + 3'd1;
			end
		end
	end

endmodule

/* design/vpe_bound.sv */
// Period to estimate: scale in range, clamp to a bound outside it
module vpe_bound
	import vpe_pkg::*;
#(
	parameter int AGE_BITS = 16
) (
	input  logic [AGE_BITS:0]   period,
	input  cfg_t                cfg,
	output logic [EST_BITS-1:0] est
);

	localparam int PER_BITS  = AGE_BITS + 1;
	localparam int CMP_BITS  = (PER_BITS > BOUND_BITS) ? PER_BITS : BOUND_BITS;
	localparam int RAW_BITS  = PER_BITS + SCALE_BITS;
	localparam int PROD_BITS = (RAW_BITS > EST_BITS) ? RAW_BITS : EST_BITS + 1;

	logic [CMP_BITS-1:0]  per_c;
	logic [CMP_BITS-1:0]  lo_c;
	logic [CMP_BITS-1:0]  up_c;
	logic [PROD_BITS-1:0] prod;

	// Compare against the bounds and saturate the scaled period
	always_comb begin
		per_c = CMP_BITS'(period);
		lo_c  = CMP_BITS'(cfg.lower_bound);
		up_c  = CMP_BITS'(cfg.upper_bound);
		prod  = PROD_BITS'(period) * PROD_BITS'(cfg.period_scale);
		if ((per_c >= lo_c) && (per_c <= up_c)) begin
			est = (prod > PROD_BITS'(EST_MAX)) ? EST_MAX : prod[EST_BITS-1:0];
		end else if (per_c > up_c) begin
			est = EST_BITS'(cfg.upper_bound);
		end else begin
			est = EST_BITS'(cfg.lower_bound);
		end
	end

endmodule

/* design/valley_period_estimator_unit.sv */
// Valley period estimator: one result beat per sample beat, one beat per clock sustained.
// Each sample beat is captured in an input register and then, once the output register is free,
// produces exactly one result beat there: throughput one sample per clock with no stall of its
// own; only downstream back-pressure slows it. The cycle is set by the acceptance path: age
// increment, two-gap add, 17x8 multiply and saturation feeding the held estimate. A valley is
// the sample two back when it is below the sample four back, below the new sample and below
// valley_level; it counts only if more than min_spacing samples follow the previous accepted
// valley. From the third accepted valley on, each acceptance measures the span back to the
// valley two before and loads the estimate (scaled if within the bounds, else the bound
// crossed); updated marks beats on which a valley was accepted. Configuration must be written
// only when idle; the block itself does not enforce this.
`include "valley_period_estimator_unit_macros.svh"

module valley_period_estimator_unit
	import vpe_pkg::*;
#(
	parameter int SAMPLE_BITS = 12,
	parameter int AGE_BITS    = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration write port
	input  logic                               cfg_we,
	input  logic [CFG_IDX_BITS-1:0]            cfg_index,
	input  logic [CFG_DAT_BITS-1:0]            cfg_data,
	// sample stream
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]   s_tdata,   // sample
	// result stream
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [EST_BITS-1:0]                m_tdata,   // estimate
	output logic                               m_tuser    // updated
);

	localparam int PER_BITS = AGE_BITS + 1;
	localparam int SP_BITS  = (AGE_BITS > BOUND_BITS) ? AGE_BITS : BOUND_BITS;
	localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

	cfg_t                   cfg_q;
	logic                   valid_s1;
	logic [SAMPLE_BITS-1:0] sample_s1;
	logic                   out_valid_q;
	logic [EST_BITS-1:0]    est_q;
	logic                   updated_q;

	logic [1:0]             acc_q;
	logic [AGE_BITS-1:0]    age_q;
	logic [AGE_BITS-1:0]    prev_gap_q;
	logic [EST_BITS-1:0]    held_q;

	logic                   advance;
	logic                   fire;
	logic                   valley;
	logic [AGE_BITS-1:0]    gap;
	logic                   spaced;
	logic                   accept;
	logic                   measure;
	logic [PER_BITS-1:0]    period;
	logic [EST_BITS-1:0]    bound_est;
	logic [EST_BITS-1:0]    est_next;

	// Handshake: the result register frees up when empty or taken
	assign advance  = !out_valid_q || m_tready;
	assign fire     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = est_q;
	assign m_tuser  = updated_q;

	vpe_history #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_history (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (fire),
		.sample (sample_s1),
		.level  (cfg_q.valley_level),
		.valley (valley)
	);

	vpe_bound #(
		.AGE_BITS(AGE_BITS)
	) u_bound (
		.period (period),
		.cfg    (cfg_q),
		.est    (bound_est)
	);

	// Decide acceptance and the measured period for the beat in stage one
	always_comb begin
		gap      = (age_q == AGE_MAX) ? age_q : age_q + 1'b1;
		spaced   = SP_BITS'(gap) > SP_BITS'(cfg_q.min_spacing);
		accept   = valley && ((acc_q == ACC_NONE) || spaced);
		measure  = accept && (acc_q >= ACC_MEASURE);
		period   = PER_BITS'(gap) + PER_BITS'(prev_gap_q);
		est_next = measure ? bound_est : held_q;
	end

	// Input register valid and result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	// Payload: capture the sample, hold the result beat
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			sample_s1 <= s_tdata[SAMPLE_BITS-1:0];
		end
		if (fire) begin
			est_q     <= est_next;
			updated_q <= accept;
		end
	end

	// Valley tracking state and configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q      <= CFG_RESET;
			acc_q      <= ACC_NONE;
			age_q      <= '0;
			prev_gap_q <= '0;
			held_q     <= EST_BITS'(CFG_RESET.initial_estimate);
		end else begin
			if (fire) begin
				age_q <= accept ? '0 : gap;
				if (accept && (acc_q != ACC_NONE)) begin
					prev_gap_q <= gap;
				end
				if (accept && (acc_q != ACC_FULL)) begin
					acc_q <= acc_q + 2'd1;
				end
				if (measure) begin
					held_q <= bound_est;
				end
			end
			if (cfg_we) begin
				unique case (cfg_index)
					REG_VALLEY_LEVEL:     cfg_q.valley_level <= cfg_data[LEVEL_BITS-1:0];
					REG_MIN_SPACING:      cfg_q.min_spacing  <= cfg_data[BOUND_BITS-1:0];
					REG_UPPER_BOUND:      cfg_q.upper_bound  <= cfg_data[BOUND_BITS-1:0];
					REG_LOWER_BOUND:      cfg_q.lower_bound  <= cfg_data[BOUND_BITS-1:0];
					REG_PERIOD_SCALE:     cfg_q.period_scale <= cfg_data[SCALE_BITS-1:0];
					REG_INITIAL_ESTIMATE: begin
						cfg_q.initial_estimate <= cfg_data[BOUND_BITS-1:0];
						if (acc_q != ACC_FULL) begin
							held_q <= EST_BITS'(cfg_data[BOUND_BITS-1:0]);
						end
					end
					default: ;
				endcase
			end
		end
	end

	// An accepted valley restarts the age count
	`VPE_ASSERT_NEXT(a_age_restart, clk, arst_n, fire && accept, age_q == '0, "age not cleared on accepted valley")

	// Without a valley or a write, the held estimate stays put
	`VPE_ASSERT_NEXT(a_held_stable, clk, arst_n, !(fire && accept) && !cfg_we, $stable(held_q), "held estimate moved without cause")

	// A result flagged updated means at least one valley is on record
	`VPE_ASSERT_NOW(a_updated_count, clk, arst_n, out_valid_q && updated_q, acc_q != ACC_NONE, "updated beat with no accepted valley")

endmodule

/* bench/tb_valley_period_estimator_unit.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the valley period estimator unit
module tb_valley_period_estimator_unit;
	import vpe_pkg::*;

	// Indexes beyond the register map; writes there must leave everything untouched
	localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_LOW  = 3'd6;
	localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_HIGH = 3'd7;

	localparam int SAMPLE_W      = 12;
	localparam int WORD_W        = 16;
	localparam int STALL_LIMIT   = 2000;
	localparam int RANDOM_PHASES = 9;
	localparam int PHASE_SAMPLES = 190;
	localparam int LONG_RUN      = 30;

	typedef struct packed {
		logic [EST_BITS-1:0] estimate;
		logic                updated;
	} outcome_t;

	// Tracks the estimator state and holds the estimates still owed by the block
	class estimate_tracker;
		cfg_t                regs;
		logic [SAMPLE_W-1:0] history [4];
		logic [2:0]          fill;
		logic [1:0]          accepted;
		logic [15:0]         age;
		logic [15:0]         last_gap;
		logic [EST_BITS-1:0] held;
		outcome_t            due [$];
		int                  samples;
		int                  results;
		int                  valleys;
		int                  failures;

		function new();
			regs     = CFG_RESET;
			foreach (history[k])
				history[k] = '0;
			fill     = '0;
			accepted = ACC_NONE;
			age      = '0;
			last_gap = '0;
			held     = EST_BITS'(CFG_RESET.initial_estimate);
			samples  = 0;
			results  = 0;
			valleys  = 0;
			failures = 0;
		endfunction

		// Scale an in-range period, otherwise clamp to the bound it crossed
		function logic [EST_BITS-1:0] bounded(logic [16:0] span);
			logic [24:0] product;
			product = 25'(span) * 25'(regs.period_scale);
			if (span >= 17'(regs.lower_bound) && span <= 17'(regs.upper_bound))
				return (product > 25'(EST_MAX)) ? EST_MAX : product[EST_BITS-1:0];
			if (span > 17'(regs.upper_bound))
				return EST_BITS'(regs.upper_bound);
			return EST_BITS'(regs.lower_bound);
		endfunction

		function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DAT_BITS-1:0] data);
			case (idx)
				REG_VALLEY_LEVEL:     regs.valley_level = data[LEVEL_BITS-1:0];
				REG_MIN_SPACING:      regs.min_spacing  = data;
				REG_UPPER_BOUND:      regs.upper_bound  = data;
				REG_LOWER_BOUND:      regs.lower_bound  = data;
				REG_PERIOD_SCALE:     regs.period_scale = data[SCALE_BITS-1:0];
				REG_INITIAL_ESTIMATE: begin
					regs.initial_estimate = data;
					if (accepted != ACC_FULL)
						held = EST_BITS'(data);
				end
				default: ;
			endcase
		endfunction

		// Advance the state by one sample beat and queue the estimate it yields
		function void take_sample(logic [WORD_W-1:0] word);
			logic [SAMPLE_W-1:0] s;
			logic [SAMPLE_W-1:0] cur;
			logic [SAMPLE_W-1:0] prev;
			logic [15:0]         gap;
			logic                hit;
			s    = word[SAMPLE_W-1:0];
			cur  = history[1];
			prev = history[3];
			hit  = 1'b0;
			gap  = (age == '1) ? age : age + 16'd1;
			age  = gap;
			if (fill >= FILL_FULL && cur < prev && s > cur && cur < regs.valley_level) begin
				if (accepted == ACC_NONE) begin
					hit = 1'b1;
				end else if (gap > regs.min_spacing) begin
					hit = 1'b1;
					if (accepted >= ACC_MEASURE)
						held = bounded(17'(gap) + 17'(last_gap));
					last_gap = gap;
				end
				if (hit) begin
					age = '0;
					if (accepted != ACC_FULL)
						accepted = accepted + 2'd1;
				end
			end
			history[3] = history[2];
			history[2] = history[1];
			history[1] = history[0];
			history[0] = s;
			if (fill < FILL_FULL)
				fill = fill + 3'd1;
			due.push_back('{estimate: held, updated: hit});
			samples++;
		endfunction

		function void check_estimate(logic [EST_BITS-1:0] est, logic upd);
			outcome_t want;
			results++;
			if (due.size() == 0) begin
				$error("result beat with no sample pending: estimate %0d updated %0b", est, upd);
				failures++;
				return;
			end
			want = due.pop_front();
			if (want.updated)
				valleys++;
			if (est !== want.estimate) begin
				$error("estimate: expected %0d, actual %0d", want.estimate, est);
				failures++;
			end
			if (upd !== want.updated) begin
				$error("updated: expected %0b, actual %0b", want.updated, upd);
				failures++;
			end
		endfunction
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [CFG_DAT_BITS-1:0] cfg_data = '0;
	logic                    s_tvalid = 1'b0;
	logic                    s_tready;
	logic [WORD_W-1:0]       s_tdata = '0;   // sample
	logic                    m_tvalid;
	logic                    m_tready = 1'b0;
	logic [EST_BITS-1:0]     m_tdata;        // estimate
	logic                    m_tuser;        // updated

	estimate_tracker book = new();
	bit              steady = 1'b0;
	bit              armed = 1'b0;
	int              quiet = 0;
	int              settings = 0;

	valley_period_estimator_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Stall the result side at random unless in a steady stretch
	always @(posedge clk) begin
		m_tready <= steady || ($urandom_range(0, 99) >= 9);
	end

	// Observe both streams on every edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				book.take_sample(s_tdata);
			if (m_tvalid && m_tready)
				book.check_estimate(m_tdata, m_tuser);
		end
	end

	// Abort when neither stream nor the register port has moved for too long
	always @(posedge clk) begin
		if (armed) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
				quiet = 0;
			end else begin
				quiet++;
				if (quiet >= STALL_LIMIT) begin
					$display("FAIL valley_period_estimator_unit");
					$finish;
				end
			end
		end
	end

	task automatic cfg_write(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DAT_BITS-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		book.write_reg(idx, data);
	endtask

	// Drive one sample beat; valid is left high so back-to-back beats need no extra edge
	task automatic send_word(logic [WORD_W-1:0] word);
		while (!steady && $urandom_range(0, 99) < 9) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= word;
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	// Ignored upper bits carry noise
	task automatic send_sample(logic [SAMPLE_W-1:0] value);
		send_word({4'($urandom), value});
	endtask

	// Drop valid and hold until every owed result has come back
	task automatic settle();
		s_tvalid <= 1'b0;
		while (book.due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_opening();
		logic [WORD_W-1:0] first_burst [$];
		logic [WORD_W-1:0] second_burst [$];
		first_burst  = '{16'hFFFF, 16'h0FFF, 16'h0FFF, 16'h0FFF, 16'h0000, 16'h0FFF,
			16'h0FFF, 16'hF000, 16'h0FFF, 16'h0FFF, 16'h0FFF};
		second_burst = '{16'h0005, 16'h0FFF, 16'h0FFF, 16'h0FFF, 16'h0FFF, 16'h0FFE,
			16'h0FFF, 16'h0FFF, 16'h0FFF, 16'h0FFF, 16'h0003, 16'h0FFF, 16'h0FFF, 16'h0FFF};
		// Widest initial estimate, tight spacing, level at its maximum
		cfg_write(REG_INITIAL_ESTIMATE, 16'hFFFF);
		cfg_write(REG_MIN_SPACING, 16'd3);
		cfg_write(REG_VALLEY_LEVEL, 16'hFFFF);
		cfg_we <= 1'b0;
		settings++;
		// Warm-up, a first valley and one that comes too close
		foreach (first_burst[k])
			send_word(first_burst[k]);
		settle();
		// Reload the initial estimate before the third valley lands
		cfg_write(REG_INITIAL_ESTIMATE, 16'd1234);
		cfg_we <= 1'b0;
		foreach (second_burst[k])
			send_word(second_burst[k]);
		settle();
	endtask

	function automatic logic [15:0] pick(logic [15:0] floor_v, logic [15:0] ceil_v,
		int lo, int hi);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 6)
			return floor_v;
		if (roll < 12)
			return ceil_v;
		return 16'($urandom_range(lo, hi));
	endfunction

	// Write a full register setting; the first phases pin the corner cases
	task automatic apply_setting(int phase);
		cfg_t pick_cfg;
		pick_cfg.valley_level     = 12'(pick(16'd0, 16'd4095, 1000, 4095));
		pick_cfg.min_spacing      = pick(16'd0, 16'hFFFF, 0, 15);
		pick_cfg.upper_bound      = pick(16'd0, 16'hFFFF, 20, 120);
		pick_cfg.lower_bound      = pick(16'd0, 16'hFFFF, 0, 40);
		pick_cfg.period_scale     = 8'(pick(16'd0, 16'd255, 1, 255));
		pick_cfg.initial_estimate = 16'($urandom);
		case (phase)
			0: begin
				// crossed bounds with upper at zero and zero scale
				pick_cfg.valley_level = 12'd4095;
				pick_cfg.min_spacing  = 16'd0;
				pick_cfg.upper_bound  = 16'd0;
				pick_cfg.lower_bound  = 16'hFFFF;
				pick_cfg.period_scale = 8'd0;
			end
			1: begin
				// crossed bounds that both periods above and below can reach
				pick_cfg.valley_level = 12'd4095;
				pick_cfg.min_spacing  = 16'd2;
				pick_cfg.upper_bound  = 16'd20;
				pick_cfg.lower_bound  = 16'd60;
				pick_cfg.period_scale = 8'd3;
			end
			2: begin
				// every period in range, but scaled by zero
				pick_cfg.valley_level = 12'd3000;
				pick_cfg.min_spacing  = 16'd1;
				pick_cfg.upper_bound  = 16'hFFFF;
				pick_cfg.lower_bound  = 16'd0;
				pick_cfg.period_scale = 8'd0;
			end
			3: begin
				pick_cfg.min_spacing  = 16'd0;
				pick_cfg.upper_bound  = 16'd120;
				pick_cfg.lower_bound  = 16'd0;
				pick_cfg.period_scale = 8'd255;
			end
			default: ;
		endcase
		cfg_write(REG_VALLEY_LEVEL, {4'($urandom), pick_cfg.valley_level});
		cfg_write(REG_MIN_SPACING, pick_cfg.min_spacing);
		cfg_write(REG_UPPER_BOUND, pick_cfg.upper_bound);
		cfg_write(REG_LOWER_BOUND, pick_cfg.lower_bound);
		cfg_write(REG_PERIOD_SCALE, {8'($urandom), pick_cfg.period_scale});
		cfg_write(REG_INITIAL_ESTIMATE, pick_cfg.initial_estimate);
		cfg_write($urandom_range(0, 1) ? REG_SPARE_HIGH : REG_SPARE_LOW, 16'($urandom));
		cfg_we <= 1'b0;
		settings++;
	endtask

	// Mostly V-shaped cycles around the valley level, with noise and flat runs
	task automatic run_wave(int count);
		int                  sent;
		int                  kind;
		int                  span;
		int                  half;
		int                  lo;
		int                  hi;
		int                  cap;
		int                  len;
		logic [SAMPLE_W-1:0] level_val;
		sent = 0;
		while (sent < count) begin
			kind = $urandom_range(0, 99);
			if (kind < 75) begin
				cap  = int'(book.regs.valley_level) + 150;
				if (cap > 4095)
					cap = 4095;
				span = $urandom_range(3, 40);
				half = span / 2;
				lo   = $urandom_range(0, cap);
				hi   = $urandom_range(lo, 4095);
				for (int i = 0; i < span; i++) begin
					if (i < half)
						send_sample(SAMPLE_W'(hi - (hi - lo) * i / half));
					else
						send_sample(SAMPLE_W'(lo + (hi - lo) * (i - half) / (span - half)));
				end
				sent += span;
			end else if (kind < 90) begin
				len = $urandom_range(1, 8);
				repeat (len) send_sample(SAMPLE_W'($urandom));
				sent += len;
			end else begin
				len       = $urandom_range(1, 20);
				level_val = SAMPLE_W'($urandom);
				repeat (len) send_sample(level_val);
				sent += len;
			end
		end
	endtask

	task automatic send_dip();
		send_sample(12'd2000);
		send_sample(12'd2000);
		send_sample(12'd100);
		send_sample(12'd2000);
		send_sample(12'd2000);
	endtask

	// Two long gaps between dips with the widest window, then short ones again
	task automatic run_long_gap();
		cfg_write(REG_VALLEY_LEVEL, 16'h0FFF);
		cfg_write(REG_MIN_SPACING, 16'd0);
		cfg_write(REG_UPPER_BOUND, 16'hFFFF);
		cfg_write(REG_LOWER_BOUND, 16'd0);
		cfg_write(REG_PERIOD_SCALE, 16'h00FF);
		cfg_write(REG_INITIAL_ESTIMATE, 16'($urandom));
		cfg_we <= 1'b0;
		settings++;
		send_dip();
		repeat (LONG_RUN) send_sample(12'd2000);
		send_dip();
		repeat (LONG_RUN) send_sample(12'd2000);
		repeat (4) send_dip();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		armed = 1'b1;

		run_opening();

		// Random phases; one of them runs with no idling on either side
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			apply_setting(phase);
			steady = (phase == 4);
			run_wave(PHASE_SAMPLES);
			settle();
		end
		steady = 1'b0;

		run_long_gap();
		settle();

		$display("Run covered %0d sample beats and %0d result beats, %0d valleys accepted,",
			book.samples, book.results, book.valleys);
		$display("over %0d register settings incl. crossed bounds, zero scale, long gaps",
			settings);
		if (book.failures == 0)
			$display("PASS valley_period_estimator_unit");
		else
			$display("FAIL valley_period_estimator_unit");
		$finish;
	end

endmodule
